// ===== design/gsf_pkg.sv =====
// shared types, constants and helpers for the grib2 section framer
// no dependencies; used by every module of the framer

package gsf_pkg;

    // width of byte counters, lengths and offsets kept inside the framer
    localparam int LEN_W = 32;
    // width of the saturating field counter
    localparam int CNT_W = 16;
    // width of the small saturating counter that tracks the byte index within a section
    localparam int K_W = 4;
    // log2 of the depth of the queue between front and back
    localparam int FIFO_AW = 1;
    localparam int FIFO_DEPTH = 1 << FIFO_AW;

    // fixed widths of the result fields on the output port
    localparam int OUT_LEN_W = 32;
    localparam int OUT_CNT_W = 16;

    typedef logic [LEN_W-1:0] t_len;
    typedef logic [CNT_W-1:0] t_cnt;
    typedef logic [K_W-1:0] t_k;
    typedef logic [FIFO_AW-1:0] t_fptr;
    typedef logic [FIFO_AW:0] t_fcnt;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_SEC0,
        PH_HDR,
        PH_BODY
    } t_phase;

    // result kinds
    localparam logic [1:0] EV_SECTION = 2'd0;
    localparam logic [1:0] EV_END     = 2'd1;
    localparam logic [1:0] EV_ERROR   = 2'd2;

    // error codes
    localparam logic [1:0] ERR_NONE    = 2'd0;
    localparam logic [1:0] ERR_INVALID = 2'd1;
    localparam logic [1:0] ERR_EDITION = 2'd2;

    // indicator section layout
    localparam int SEC0_LEN      = 16;
    localparam int MAGIC_LEN     = 4;
    localparam int POS_DISC      = 6;
    localparam int POS_EDITION   = 7;
    localparam int POS_LEN_FIRST = 12;
    localparam int POS_LEN_LAST  = 15;
    localparam logic [7:0] EDITION = 8'd2;

    // section header layout and limits
    localparam int LEN_BYTES     = 4;
    localparam int MIN_SEC       = 5;
    localparam int MIN_SEC1      = 21;
    localparam logic [31:0] END_WORD = 32'h3737_3737;

    localparam logic [2:0] TYPE_NONE   = 3'd0;
    localparam logic [2:0] TYPE_ID     = 3'd1;
    localparam logic [2:0] TYPE_GROUP0 = 3'd3;
    localparam logic [2:0] TYPE_DATA   = 3'd7;
    localparam logic [4:0] MASK_ALL    = 5'h1f;

    // originating center and subcenter bytes within section 1
    localparam int POS_CENTER_HI = 5;
    localparam int POS_CENTER_LO = 6;
    localparam int POS_SUBC_HI   = 7;
    localparam int POS_SUBC_LO   = 8;

    // one byte with its classification, as it travels through the queue
    typedef struct packed {
        logic       start;
        logic [7:0] data;
        t_len       buflen;
        logic       short_buf;
        logic       type_ok;
        logic       ed_ok;
    } t_item;

    // one result record
    typedef struct packed {
        logic [1:0]           event_res;
        logic [1:0]           error_code;
        logic [2:0]           section_type;
        logic [OUT_LEN_W-1:0] section_offset;
        logic [OUT_LEN_W-1:0] section_length;
        logic                 field_done;
        logic [OUT_CNT_W-1:0] field_count;
        logic [7:0]           discipline;
        logic [15:0]          center;
        logic [15:0]          subcenter;
    } t_result;

    // "GRIB" magic bytes by index
    function automatic logic [7:0] gsf_magic(input logic [1:0] idx);
        logic [7:0] ch;
        case (idx)
            2'd0:    ch = 8'h47;
            2'd1:    ch = 8'h52;
            2'd2:    ch = 8'h49;
            default: ch = 8'h42;
        endcase
        return ch;
    endfunction

endpackage

// ===== design/grib2_section_framer_core.sv =====
// top level of the grib2 section framer: front, queue and back end
// depends on gsf_pkg, gsf_front, gsf_fifo and gsf_back
//
// channel   dir  handshake                        payload
// s_axis    in   i_s_axis_tvalid/o_s_axis_tready  tdata: data_byte, buffer_length;
//                                                 tuser: start_msg
// m_axis    out  o_m_axis_tvalid/i_m_axis_tready  tdata: result record; tuser: event_res
//
// one byte per cycle while results are taken, walked by the back end in its state registers
// an accepted byte passes a queue slot and then the result register before result tvalid
// a result waiting on m_axis stalls the back end only; the two-entry queue then fills
// and tready drops after that
// reset (synchronous, active low) empties the queue, drops any held result and
// leaves the walk idle until a byte with start_msg set

module grib2_section_framer_core (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // slave side
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    input  logic [39:0]  i_s_axis_tdata,   // data_byte [7:0], buffer_length [39:8]
    input  logic         i_s_axis_tuser,   // start_msg
    // master side
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    output logic [127:0] o_m_axis_tdata,   // error_code [1:0], section_type [4:2],
                                           // section_offset [36:5], section_length [68:37],
                                           // field_done [69], field_count [85:70],
                                           // discipline [93:86], center [109:94],
                                           // subcenter [125:110], zero fill [127:126]
    output logic [1:0]   o_m_axis_tuser    // event_res
);

    // front to queue
    logic             w_fq_valid;
    logic             w_fq_ready;
    gsf_pkg::t_item   w_fq_item;
    // queue to back end
    logic             w_qb_valid;
    logic             w_qb_ready;
    gsf_pkg::t_item   w_qb_item;
    // result record
    gsf_pkg::t_result w_res;

    gsf_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (i_s_axis_tvalid),
        .o_s_ready (o_s_axis_tready),
        .i_s_data  (i_s_axis_tdata),
        .i_s_start (i_s_axis_tuser),
        .o_q_valid (w_fq_valid),
        .i_q_ready (w_fq_ready),
        .o_q_item  (w_fq_item)
    );

    gsf_fifo u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_valid (w_fq_valid),
        .o_wr_ready (w_fq_ready),
        .i_wr_item  (w_fq_item),
        .o_rd_valid (w_qb_valid),
        .i_rd_ready (w_qb_ready),
        .o_rd_item  (w_qb_item)
    );

    gsf_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (w_qb_valid),
        .o_q_ready   (w_qb_ready),
        .i_q_item    (w_qb_item),
        .o_res_valid (o_m_axis_tvalid),
        .i_res_ready (i_m_axis_tready),
        .o_res       (w_res)
    );

    // pack the record, first field in the lowest bits
    assign o_m_axis_tdata = {
        2'b00,
        w_res.subcenter,
        w_res.center,
        w_res.discipline,
        w_res.field_count,
        w_res.field_done,
        w_res.section_length,
        w_res.section_offset,
        w_res.section_type,
        w_res.error_code
    };
    assign o_m_axis_tuser = w_res.event_res;

endmodule

// ===== design/gsf_front.sv =====
// front end of the grib2 section framer: takes a byte and classifies it
// depends on gsf_pkg

module gsf_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_s_valid,
    output logic           o_s_ready,
    input  logic [39:0]    i_s_data,
    input  logic           i_s_start,
    output logic           o_q_valid,
    input  logic           i_q_ready,
    output gsf_pkg::t_item o_q_item
);

    gsf_pkg::t_len w_buflen;
    logic [7:0]    w_byte;
    logic          r_seen_start;

    assign w_byte   = i_s_data[7:0];
    assign w_buflen = gsf_pkg::t_len'(i_s_data[39:8]);

    // tracks whether a start has ever arrived; bytes before the first one are dropped here
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen_start <= 1'b0;
        end else if (i_s_valid && o_s_ready && i_s_start) begin
            r_seen_start <= 1'b1;
        end
    end

    always_comb begin
        o_q_item.start     = i_s_start;
        o_q_item.data      = w_byte;
        o_q_item.buflen    = w_buflen;
        o_q_item.short_buf = (w_buflen < gsf_pkg::t_len'(gsf_pkg::SEC0_LEN));
        o_q_item.type_ok   = (w_byte >= 8'(gsf_pkg::TYPE_ID)) &&
                             (w_byte <= 8'(gsf_pkg::TYPE_DATA));
        o_q_item.ed_ok     = (w_byte == gsf_pkg::EDITION);
    end

    // bytes before any start are consumed without entering the queue
    assign o_q_valid = i_s_valid && (r_seen_start || i_s_start);
    assign o_s_ready = i_q_ready;

endmodule

// ===== design/gsf_fifo.sv =====
// short queue between the front and back of the grib2 section framer
// depends on gsf_pkg

module gsf_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_wr_valid,
    output logic           o_wr_ready,
    input  gsf_pkg::t_item i_wr_item,
    output logic           o_rd_valid,
    input  logic           i_rd_ready,
    output gsf_pkg::t_item o_rd_item
);

    gsf_pkg::t_item r_mem [gsf_pkg::FIFO_DEPTH];
    gsf_pkg::t_fptr r_wr_ptr;
    gsf_pkg::t_fptr r_rd_ptr;
    gsf_pkg::t_fcnt r_count;
    logic           w_push;
    logic           w_pop;

    assign o_wr_ready = (r_count != gsf_pkg::t_fcnt'(gsf_pkg::FIFO_DEPTH));
    assign o_rd_valid = (r_count != '0);
    assign o_rd_item  = r_mem[r_rd_ptr];
    assign w_push     = i_wr_valid && o_wr_ready;
    assign w_pop      = o_rd_valid && i_rd_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_wr_item;
        end
    end

endmodule

// ===== design/gsf_back.sv =====
// back end of the grib2 section framer: message walk and result register
// depends on gsf_pkg

module gsf_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_q_valid,
    output logic             o_q_ready,
    input  gsf_pkg::t_item   i_q_item,
    output logic             o_res_valid,
    input  logic             i_res_ready,
    output gsf_pkg::t_result o_res
);

    gsf_pkg::t_phase r_phase, n_phase, c_phase;
    gsf_pkg::t_len   r_pos, n_pos, c_pos;
    gsf_pkg::t_len   r_remain, n_remain, c_remain;
    logic [31:0]     r_shift, n_shift, c_shift;
    gsf_pkg::t_len   r_sec_left, n_sec_left, c_sec_left;
    gsf_pkg::t_len   r_sec_start, n_sec_start, c_sec_start;
    logic [2:0]      r_type, n_type, c_type;
    logic            r_first, n_first, c_first;
    logic [4:0]      r_mask, n_mask, c_mask;
    gsf_pkg::t_cnt   r_fields, n_fields, c_fields;
    logic [7:0]      r_disc, n_disc, c_disc;
    logic [15:0]     r_center, n_center, c_center;
    logic [15:0]     r_subc, n_subc, c_subc;
    gsf_pkg::t_k     r_k, n_k, c_k;

    logic             r_out_valid;
    gsf_pkg::t_result r_out;
    gsf_pkg::t_result w_res;
    logic             w_res_valid;
    logic             w_pop;
    logic             w_fail;
    logic [1:0]       w_fail_code;
    logic [31:0]      w_shift_new;
    logic [7:0]       w_b;
    gsf_pkg::t_k      w_k_inc;

    assign o_q_ready   = !r_out_valid || i_res_ready;
    assign w_pop       = i_q_valid && o_q_ready;
    assign o_res_valid = r_out_valid;
    assign o_res       = r_out;

    always_comb begin
        // a start byte restarts the walk before the byte itself is looked at
        c_phase     = r_phase;
        c_pos       = r_pos;
        c_remain    = r_remain;
        c_shift     = r_shift;
        c_sec_left  = r_sec_left;
        c_sec_start = r_sec_start;
        c_type      = r_type;
        c_first     = r_first;
        c_mask      = r_mask;
        c_fields    = r_fields;
        c_disc      = r_disc;
        c_center    = r_center;
        c_subc      = r_subc;
        c_k         = r_k;
        if (i_q_item.start) begin
            c_phase     = gsf_pkg::PH_SEC0;
            c_pos       = '0;
            c_remain    = i_q_item.buflen;
            c_shift     = '0;
            c_sec_left  = '0;
            c_sec_start = '0;
            c_type      = gsf_pkg::TYPE_NONE;
            c_first     = 1'b1;
            c_mask      = '0;
            c_fields    = '0;
            c_disc      = '0;
            c_center    = '0;
            c_subc      = '0;
            c_k         = '0;
        end

        n_phase     = c_phase;
        n_pos       = c_pos;
        n_remain    = c_remain;
        n_shift     = c_shift;
        n_sec_left  = c_sec_left;
        n_sec_start = c_sec_start;
        n_type      = c_type;
        n_first     = c_first;
        n_mask      = c_mask;
        n_fields    = c_fields;
        n_disc      = c_disc;
        n_center    = c_center;
        n_subc      = c_subc;
        n_k         = c_k;

        w_b         = i_q_item.data;
        w_shift_new = {c_shift[23:0], w_b};
        w_k_inc     = (c_k == '1) ? c_k : c_k + 1'b1;
        w_fail      = 1'b0;
        w_fail_code = gsf_pkg::ERR_INVALID;
        w_res_valid = 1'b0;

        w_res.event_res    = gsf_pkg::EV_SECTION;
        w_res.error_code   = gsf_pkg::ERR_NONE;
        w_res.section_type = gsf_pkg::TYPE_NONE;
        w_res.section_length = '0;
        w_res.field_done   = 1'b0;

        if (i_q_item.start && i_q_item.short_buf) begin
            w_fail = 1'b1;
        end else if (c_phase != gsf_pkg::PH_IDLE) begin
            n_pos = c_pos + 1'b1;
            case (c_phase)
                gsf_pkg::PH_SEC0: begin
                    if (c_pos < gsf_pkg::t_len'(gsf_pkg::MAGIC_LEN)) begin
                        if (w_b != gsf_pkg::gsf_magic(c_pos[1:0])) begin
                            w_fail = 1'b1;
                        end
                    end else if (c_pos == gsf_pkg::t_len'(gsf_pkg::POS_DISC)) begin
                        n_disc = w_b;
                    end else if (c_pos == gsf_pkg::t_len'(gsf_pkg::POS_EDITION)) begin
                        if (!i_q_item.ed_ok) begin
                            w_fail      = 1'b1;
                            w_fail_code = gsf_pkg::ERR_EDITION;
                        end
                    end else if (c_pos >= gsf_pkg::t_len'(gsf_pkg::POS_LEN_FIRST) &&
                                 c_pos <= gsf_pkg::t_len'(gsf_pkg::POS_LEN_LAST)) begin
                        n_shift = w_shift_new;
                        if (c_pos == gsf_pkg::t_len'(gsf_pkg::POS_LEN_LAST)) begin
                            if (w_shift_new > 32'(c_remain)) begin
                                w_fail = 1'b1;
                            end else begin
                                n_remain = c_remain - gsf_pkg::t_len'(gsf_pkg::SEC0_LEN);
                                if (n_remain < gsf_pkg::t_len'(gsf_pkg::LEN_BYTES)) begin
                                    w_fail = 1'b1;
                                end else begin
                                    n_sec_start = gsf_pkg::t_len'(gsf_pkg::SEC0_LEN);
                                    n_shift     = '0;
                                    n_phase     = gsf_pkg::PH_HDR;
                                    n_k         = '0;
                                end
                            end
                        end
                    end
                end
                gsf_pkg::PH_HDR: begin
                    n_k = w_k_inc;
                    if (c_k < gsf_pkg::t_k'(gsf_pkg::LEN_BYTES)) begin
                        n_shift = w_shift_new;
                        if (c_k == gsf_pkg::t_k'(gsf_pkg::LEN_BYTES - 1)) begin
                            if (w_shift_new == gsf_pkg::END_WORD) begin
                                n_phase         = gsf_pkg::PH_IDLE;
                                w_res_valid     = 1'b1;
                                w_res.event_res = gsf_pkg::EV_END;
                            end else if (c_remain < gsf_pkg::t_len'(gsf_pkg::MIN_SEC) ||
                                         w_shift_new < 32'(gsf_pkg::MIN_SEC) ||
                                         w_shift_new > 32'(c_remain)) begin
                                w_fail = 1'b1;
                            end
                        end
                    end else begin
                        // type byte
                        if (!i_q_item.type_ok) begin
                            w_fail = 1'b1;
                        end else if (w_b[2:0] == gsf_pkg::TYPE_ID &&
                                     c_shift < 32'(gsf_pkg::MIN_SEC1)) begin
                            w_fail = 1'b1;
                        end else if (c_first && w_b[2:0] != gsf_pkg::TYPE_ID) begin
                            w_fail = 1'b1;
                        end else begin
                            n_first = 1'b0;
                            n_type  = w_b[2:0];
                            if (w_b[2:0] >= gsf_pkg::TYPE_GROUP0) begin
                                n_mask = c_mask | (5'd1 << (w_b[2:0] - gsf_pkg::TYPE_GROUP0));
                            end
                            if (w_b[2:0] == gsf_pkg::TYPE_DATA) begin
                                if (n_mask != gsf_pkg::MASK_ALL) begin
                                    w_fail = 1'b1;
                                end else begin
                                    if (c_fields != '1) begin
                                        n_fields = c_fields + 1'b1;
                                    end
                                    w_res.field_done = 1'b1;
                                end
                            end
                            if (!w_fail) begin
                                n_remain   = c_remain - gsf_pkg::t_len'(c_shift);
                                n_sec_left = gsf_pkg::t_len'(c_shift - 32'(gsf_pkg::MIN_SEC));
                                w_res_valid          = 1'b1;
                                w_res.section_type   = w_b[2:0];
                                w_res.section_length = c_shift;
                                if (c_shift == 32'(gsf_pkg::MIN_SEC)) begin
                                    // header-only section: next one starts right away
                                    if (n_remain < gsf_pkg::t_len'(gsf_pkg::LEN_BYTES)) begin
                                        w_fail = 1'b1;
                                    end else begin
                                        n_sec_start = c_pos + 1'b1;
                                        n_shift     = '0;
                                        n_phase     = gsf_pkg::PH_HDR;
                                        n_k         = '0;
                                    end
                                end else begin
                                    n_phase = gsf_pkg::PH_BODY;
                                end
                            end
                        end
                    end
                end
                gsf_pkg::PH_BODY: begin
                    n_k = w_k_inc;
                    if (c_sec_start == gsf_pkg::t_len'(gsf_pkg::SEC0_LEN) &&
                        c_type == gsf_pkg::TYPE_ID) begin
                        if (c_k == gsf_pkg::t_k'(gsf_pkg::POS_CENTER_HI)) begin
                            n_center[15:8] = w_b;
                        end else if (c_k == gsf_pkg::t_k'(gsf_pkg::POS_CENTER_LO)) begin
                            n_center[7:0] = w_b;
                        end else if (c_k == gsf_pkg::t_k'(gsf_pkg::POS_SUBC_HI)) begin
                            n_subc[15:8] = w_b;
                        end else if (c_k == gsf_pkg::t_k'(gsf_pkg::POS_SUBC_LO)) begin
                            n_subc[7:0] = w_b;
                        end
                    end
                    n_sec_left = c_sec_left - 1'b1;
                    if (c_sec_left == gsf_pkg::t_len'(1)) begin
                        if (c_remain < gsf_pkg::t_len'(gsf_pkg::LEN_BYTES)) begin
                            w_fail = 1'b1;
                        end else begin
                            n_sec_start = c_pos + 1'b1;
                            n_shift     = '0;
                            n_phase     = gsf_pkg::PH_HDR;
                            n_k         = '0;
                        end
                    end
                end
                default: begin
                    n_phase = gsf_pkg::PH_IDLE;
                end
            endcase
        end

        if (w_fail) begin
            n_phase              = gsf_pkg::PH_IDLE;
            w_res_valid          = 1'b1;
            w_res.event_res      = gsf_pkg::EV_ERROR;
            w_res.error_code     = w_fail_code;
            w_res.section_type   = gsf_pkg::TYPE_NONE;
            w_res.section_length = '0;
            w_res.field_done     = 1'b0;
        end

        w_res.section_offset = gsf_pkg::OUT_LEN_W'(c_sec_start);
        w_res.field_count    = gsf_pkg::OUT_CNT_W'(n_fields);
        w_res.discipline     = n_disc;
        w_res.center         = n_center;
        w_res.subcenter      = n_subc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= gsf_pkg::PH_IDLE;
        end else if (w_pop) begin
            r_phase <= n_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pop) begin
            r_pos       <= n_pos;
            r_remain    <= n_remain;
            r_shift     <= n_shift;
            r_sec_left  <= n_sec_left;
            r_sec_start <= n_sec_start;
            r_type      <= n_type;
            r_first     <= n_first;
            r_mask      <= n_mask;
            r_fields    <= n_fields;
            r_disc      <= n_disc;
            r_center    <= n_center;
            r_subc      <= n_subc;
            r_k         <= n_k;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_pop && w_res_valid) begin
            r_out_valid <= 1'b1;
        end else if (i_res_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pop && w_res_valid) begin
            r_out <= w_res;
        end
    end

endmodule

// ===== tb/gsf_tb_pkg.sv =====
// section record checker for the grib2 section framer testbench
// depends on gsf_pkg for the phase enum, the result record and the format constants
`timescale 1ns / 100ps

package gsf_tb_pkg;

    import gsf_pkg::*;

    localparam logic [31:0] MAGIC_WORD = 32'h4752_4942;

    class section_checker;

        // walk state, mirrored from the framer's behavior
        t_phase      walk;
        logic [31:0] byte_at;
        logic [31:0] buf_left;
        logic [31:0] shifter;
        logic [31:0] body_left;
        logic [31:0] sec_start;
        logic [2:0]  cur_kind;
        bit          first_sec;
        logic [4:0]  kinds_seen;
        logic [15:0] fields;
        logic [7:0]  disc;
        logic [15:0] center;
        logic [15:0] subcenter;

        t_result     records_due[$];
        int unsigned fault_count;
        int unsigned records_seen;

        function new();
            restart(32'd0);
            walk = PH_IDLE;
            fault_count = 0;
            records_seen = 0;
        endfunction

        function void restart(logic [31:0] buflen);
            walk = PH_SEC0;
            byte_at = '0;
            buf_left = buflen;
            shifter = '0;
            body_left = '0;
            sec_start = '0;
            cur_kind = TYPE_NONE;
            first_sec = 1'b1;
            kinds_seen = '0;
            fields = '0;
            disc = '0;
            center = '0;
            subcenter = '0;
        endfunction

        function void log_record(logic [1:0] ev, logic [1:0] err, logic [2:0] kind,
                                 logic [31:0] off, logic [31:0] len, bit done);
            t_result r;
            r.event_res = ev;
            r.error_code = err;
            r.section_type = kind;
            r.section_offset = off;
            r.section_length = len;
            r.field_done = done;
            r.field_count = fields;
            r.discipline = disc;
            r.center = center;
            r.subcenter = subcenter;
            records_due.push_back(r);
        endfunction

        function void abort_walk(logic [1:0] err);
            walk = PH_IDLE;
            log_record(EV_ERROR, err, TYPE_NONE, sec_start, '0, 1'b0);
        endfunction

        // returns 1 when the buffer tail is too short and an error was logged
        function bit close_section(logic [31:0] next_start);
            if (buf_left < LEN_BYTES) begin
                abort_walk(ERR_INVALID);
                return 1'b1;
            end
            sec_start = next_start;
            shifter = '0;
            walk = PH_HDR;
            return 1'b0;
        endfunction

        // notes one accepted byte; returns 0 when the framer ignores it
        function bit take_byte(bit first, logic [7:0] b, logic [31:0] buflen);
            logic [31:0] p;
            logic [31:0] k;
            logic [31:0] off;
            logic [31:0] len;
            bit          done;
            if (first) begin
                restart(buflen);
                if (buf_left < SEC0_LEN) begin
                    abort_walk(ERR_INVALID);
                    return 1'b1;
                end
            end
            if (walk == PH_IDLE)
                return 1'b0;
            p = byte_at;
            byte_at = byte_at + 1;
            k = p - sec_start;
            case (walk)
                PH_SEC0: begin
                    if (p < MAGIC_LEN) begin
                        if (b != MAGIC_WORD[31 - 8 * int'(p) -: 8])
                            abort_walk(ERR_INVALID);
                    end else if (p == POS_DISC) begin
                        disc = b;
                    end else if (p == POS_EDITION) begin
                        if (b != EDITION)
                            abort_walk(ERR_EDITION);
                    end else if (p >= POS_LEN_FIRST && p <= POS_LEN_LAST) begin
                        shifter = {shifter[23:0], b};
                        if (p == POS_LEN_LAST) begin
                            if (shifter > buf_left) begin
                                abort_walk(ERR_INVALID);
                            end else begin
                                buf_left = buf_left - SEC0_LEN;
                                void'(close_section(SEC0_LEN));
                            end
                        end
                    end
                end
                PH_HDR: begin
                    if (k < LEN_BYTES) begin
                        shifter = {shifter[23:0], b};
                        if (k == LEN_BYTES - 1) begin
                            if (shifter == END_WORD) begin
                                walk = PH_IDLE;
                                log_record(EV_END, ERR_NONE, TYPE_NONE, sec_start, '0, 1'b0);
                            end else if (buf_left < MIN_SEC || shifter < MIN_SEC ||
                                         shifter > buf_left) begin
                                abort_walk(ERR_INVALID);
                            end
                        end
                    end else if (b < 1 || b > 7 || (b == TYPE_ID && shifter < MIN_SEC1) ||
                                 (first_sec && b != TYPE_ID)) begin
                        abort_walk(ERR_INVALID);
                    end else begin
                        first_sec = 1'b0;
                        cur_kind = b[2:0];
                        if (b >= TYPE_GROUP0)
                            kinds_seen[b[2:0] - TYPE_GROUP0] = 1'b1;
                        done = 1'b0;
                        if (b == TYPE_DATA && kinds_seen != MASK_ALL) begin
                            abort_walk(ERR_INVALID);
                        end else begin
                            if (b == TYPE_DATA) begin
                                if (fields != 16'hFFFF)
                                    fields = fields + 1;
                                done = 1'b1;
                            end
                            buf_left = buf_left - shifter;
                            body_left = shifter - MIN_SEC;
                            off = sec_start;
                            len = shifter;
                            if (body_left == 0) begin
                                if (!close_section(p + 1))
                                    log_record(EV_SECTION, ERR_NONE, b[2:0], off, len, done);
                            end else begin
                                walk = PH_BODY;
                                log_record(EV_SECTION, ERR_NONE, b[2:0], off, len, done);
                            end
                        end
                    end
                end
                PH_BODY: begin
                    if (sec_start == SEC0_LEN && cur_kind == TYPE_ID) begin
                        if (k == POS_CENTER_HI)
                            center[15:8] = b;
                        else if (k == POS_CENTER_LO)
                            center[7:0] = b;
                        else if (k == POS_SUBC_HI)
                            subcenter[15:8] = b;
                        else if (k == POS_SUBC_LO)
                            subcenter[7:0] = b;
                    end
                    body_left = body_left - 1;
                    if (body_left == 0)
                        void'(close_section(p + 1));
                end
                default: ;
            endcase
            return 1'b1;
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                fault_count++;
                if (fault_count <= 10)
                    $display("record %0d: %s expected 0x%0h, got 0x%0h",
                             records_seen, name, want, got);
            end
        endfunction

        // checks one accepted result transaction against the oldest expected record
        function void match_record(logic [1:0] kind, logic [127:0] word);
            t_result want;
            if (records_due.size() == 0) begin
                fault_count++;
                if (fault_count <= 10)
                    $display("result with no record due: event %0d, data 0x%h", kind, word);
                return;
            end
            want = records_due.pop_front();
            records_seen++;
            compare_field("event_res", want.event_res, kind);
            compare_field("error_code", want.error_code, word[1:0]);
            compare_field("section_type", want.section_type, word[4:2]);
            compare_field("section_offset", want.section_offset, word[36:5]);
            compare_field("section_length", want.section_length, word[68:37]);
            compare_field("field_done", want.field_done, word[69]);
            compare_field("field_count", want.field_count, word[85:70]);
            compare_field("discipline", want.discipline, word[93:86]);
            compare_field("center", want.center, word[109:94]);
            compare_field("subcenter", want.subcenter, word[125:110]);
        endfunction

    endclass

endpackage

// ===== tb/testbench.sv =====
// regression testbench for grib2_section_framer_core: builds grib2 messages, streams them
// byte by byte with random idling and checks each result record; uses gsf_pkg and gsf_tb_pkg
`timescale 1ns / 100ps

module testbench;

    import gsf_pkg::*;
    import gsf_tb_pkg::*;

    localparam int unsigned RANDOM_ITEMS = 650;
    localparam int unsigned LIMIT_CYCLES = 400000;
    localparam int unsigned DRAIN_CYCLES = 16;
    localparam int unsigned BREAK_KINDS  = 7;

    // ways a message gets broken in the random part
    typedef enum int unsigned {
        BRK_CORRUPT,     // one byte flipped anywhere
        BRK_OVERLONG,    // stated length beyond the buffer
        BRK_TAIL,        // buffer ends near a section boundary
        BRK_TRUNC,       // next start arrives mid-message
        BRK_NOFIELD,     // one of types 3 to 6 missing before the data section
        BRK_SHORT_ID,    // identification section under 21 bytes
        BRK_FIRST_TYPE   // first section is not the identification section
    } t_break;

    logic         clk;
    logic         rst_n   = 1'b0;
    logic         s_valid = 1'b0;
    logic [39:0]  s_data  = '0;     // data_byte [7:0], buffer_length [39:8]
    logic         s_user  = 1'b0;   // start_msg
    logic         m_ready = 1'b0;
    logic         s_ready;
    logic         m_valid;
    logic [127:0] m_data;
    logic [1:0]   m_user;

    section_checker sb;

    // message under construction and how it is sent
    logic [7:0]   msg_q[$];
    int unsigned  sec_starts[$];
    logic [31:0]  buf_len;
    int unsigned  send_cnt;
    bit           src_steady;
    int unsigned  items_done;
    int unsigned  cyc_count = 0;

    grib2_section_framer_core dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tuser  (s_user),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .o_m_axis_tuser  (m_user)
    );

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // watchdog on total run length
    always @(posedge clk) begin
        cyc_count <= cyc_count + 1;
        if (cyc_count > LIMIT_CYCLES) begin
            $display("grib2_section_framer_core regression: fail");
            $finish;
        end
    end

    // one byte transaction on the slave side; called at a rising edge, returns at the
    // edge that accepted it, with tvalid still high
    task automatic send_byte(input bit first, input logic [7:0] value,
                             input logic [31:0] buflen);
        int unsigned r;
        int unsigned gap;
        gap = 0;
        if (!src_steady) begin
            r = $urandom_range(0, 99);
            if (r < 70)
                gap = 0;
            else if (r < 93)
                gap = $urandom_range(1, 3);
            else if (r < 99)
                gap = $urandom_range(4, 12);
            else
                gap = $urandom_range(30, 80);
        end
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_valid <= 1'b1;
        s_data  <= {buflen, value};
        s_user  <= first;
        do @(posedge clk); while (!s_ready);
        void'(sb.take_byte(first, value, buflen));
        items_done++;
    endtask

    task automatic add_section(input logic [31:0] len, input logic [7:0] kind);
        sec_starts.push_back(msg_q.size());
        msg_q.push_back(len[31:24]);
        msg_q.push_back(len[23:16]);
        msg_q.push_back(len[15:8]);
        msg_q.push_back(len[7:0]);
        msg_q.push_back(kind);
        repeat (len - MIN_SEC) msg_q.push_back(8'($urandom));
    endtask

    // builds one message with random content, optionally broken in the given way
    task automatic build_message(input t_break brk, input bit broken);
        int unsigned nfld;
        int unsigned skip;
        int unsigned total;
        int unsigned idx;
        logic [31:0] stated;
        logic [31:0] id_len;
        logic [7:0]  first_kind;
        msg_q.delete();
        sec_starts.delete();
        // indicator section, stated length patched in at the end
        msg_q.push_back(8'h47);
        msg_q.push_back(8'h52);
        msg_q.push_back(8'h49);
        msg_q.push_back(8'h42);
        repeat (2) msg_q.push_back(8'($urandom));
        msg_q.push_back(8'($urandom));           // discipline
        msg_q.push_back(EDITION);
        repeat (4) msg_q.push_back(8'($urandom));
        repeat (4) msg_q.push_back(8'h00);

        id_len = (broken && brk == BRK_SHORT_ID) ? $urandom_range(5, 20) : $urandom_range(21, 24);
        first_kind = (broken && brk == BRK_FIRST_TYPE) ? 8'($urandom_range(2, 7)) : 8'(TYPE_ID);
        add_section(id_len, first_kind);
        if ($urandom_range(0, 3) == 0)
            add_section($urandom_range(5, 9), 8'd2);

        // first field has every type 3..7 unless BRK_NOFIELD skips one; later ones repeat a random subset with 7
        skip = (broken && brk == BRK_NOFIELD) ? $urandom_range(3, 6) : 0;
        nfld = ($urandom_range(0, 3) == 0) ? 2 : 1;
        for (int f = 0; f < nfld; f++) begin
            for (int t = 3; t <= 7; t++) begin
                if (f == 0 ? (t != skip) : (t == 7 || $urandom_range(0, 1) == 1))
                    add_section($urandom_range(5, 9), 8'(t));
            end
        end
        sec_starts.push_back(msg_q.size());
        repeat (4) msg_q.push_back(8'h37);

        total = msg_q.size();
        stated = total;
        send_cnt = total;
        case ($urandom_range(0, 4))
            0, 1: buf_len = total;
            2: begin
                // walk is bounded by the buffer, not by the stated length
                buf_len = total + $urandom_range(1, 40);
                stated = $urandom_range(SEC0_LEN, total);
            end
            default: buf_len = $urandom | 32'h0100_0000;
        endcase

        if (broken) begin
            case (brk)
                BRK_CORRUPT: begin
                    idx = $urandom_range(0, total - 1);
                    msg_q[idx] = msg_q[idx] ^ 8'($urandom_range(1, 255));
                end
                BRK_OVERLONG: begin
                    buf_len = total - $urandom_range(1, total - SEC0_LEN);
                    stated = total;
                end
                BRK_TAIL: begin
                    idx = $urandom_range(1, sec_starts.size() - 1);
                    buf_len = sec_starts[idx] + $urandom_range(0, 4);
                    stated = buf_len;
                end
                BRK_TRUNC: send_cnt = $urandom_range(1, total - 1);
                default: ;
            endcase
        end
        for (int i = 0; i < 4; i++)
            msg_q[POS_LEN_FIRST + i] = stated[31 - 8 * i -: 8];
    endtask

    task automatic send_message();
        for (int unsigned i = 0; i < send_cnt; i++)
            send_byte(i == 0, msg_q[i], (i == 0) ? buf_len : 32'($urandom));
    endtask

    // result side: random stalls, stretches of steady ready, and one long hold-off
    // that lets the framer fill up and drop tready while bytes keep coming
    initial begin : result_side
        int unsigned stall;
        int unsigned r;
        bit          held;
        stall = 0;
        held = 1'b0;
        forever begin
            @(posedge clk);
            if (m_valid && m_ready)
                sb.match_record(m_user, m_data);
            if (stall > 0) begin
                stall--;
                m_ready <= 1'b0;
            end else if (!held && sb.records_seen >= 15) begin
                held = 1'b1;
                stall = 300;
                m_ready <= 1'b0;
            end else if ((cyc_count / 300) % 3 == 0) begin
                m_ready <= 1'b1;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 65) begin
                    m_ready <= 1'b1;
                end else if (r < 95) begin
                    stall = $urandom_range(0, 2);
                    m_ready <= 1'b0;
                end else begin
                    stall = $urandom_range(10, 40);
                    m_ready <= 1'b0;
                end
            end
        end
    end

    initial begin : stimulus
        int unsigned msg_idx;
        int unsigned brk_idx;
        bit          broken;
        sb = new();
        src_steady = 1'b0;
        items_done = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // directed: idle bytes before any start are dropped
        send_byte(1'b0, 8'hFF, 32'hFFFF_FFFF);
        send_byte(1'b0, 8'h00, 32'h0000_0000);
        // buffer too short for the indicator section
        send_byte(1'b1, 8'h47, 32'd0);
        send_byte(1'b1, 8'h47, 32'd15);
        // bad magic on the last letter, largest buffer
        send_byte(1'b1, 8'h47, 32'hFFFF_FFFF);
        send_byte(1'b0, 8'h52, 32'hFFFF_FFFF);
        send_byte(1'b0, 8'h49, 32'h0000_0000);
        send_byte(1'b0, 8'h58, 32'h5555_AAAA);
        // wrong edition, discipline all ones
        send_byte(1'b1, 8'h47, 32'd16);
        send_byte(1'b0, 8'h52, 32'd0);
        send_byte(1'b0, 8'h49, 32'd0);
        send_byte(1'b0, 8'h42, 32'd0);
        send_byte(1'b0, 8'h00, 32'd0);
        send_byte(1'b0, 8'h00, 32'd0);
        send_byte(1'b0, 8'hFF, 32'd0);
        send_byte(1'b0, 8'h03, 32'd0);
        // a new start aborts the message in progress, then bad magic on its first byte
        send_byte(1'b1, 8'h47, 32'd20);
        send_byte(1'b0, 8'h52, 32'd0);
        send_byte(1'b1, 8'hB8, 32'd16);
        // dropped after the error
        send_byte(1'b0, 8'h5A, 32'd0);

        // random: well-formed messages alternate with broken ones of each kind in turn
        items_done = 0;
        msg_idx = 0;
        brk_idx = $urandom_range(0, BREAK_KINDS - 1);
        while (items_done < RANDOM_ITEMS) begin
            broken = msg_idx[0];
            build_message(t_break'(brk_idx), broken);
            if (broken)
                brk_idx = (brk_idx + 1) % BREAK_KINDS;
            src_steady = ($urandom_range(0, 3) == 0);
            send_message();
            // stray bytes between messages
            if ($urandom_range(0, 3) == 0)
                repeat ($urandom_range(1, 3)) send_byte(1'b0, 8'($urandom), 32'($urandom));
            msg_idx++;
        end
        s_valid <= 1'b0;

        // drain outstanding records, then give stray results time to show up
        while (sb.records_due.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.fault_count == 0 && sb.records_due.size() == 0) begin
            $display("grib2_section_framer_core regression: pass");
        end else begin
            $display("grib2_section_framer_core regression: fail");
        end
        $finish;
    end

endmodule
